// ===== sv/pdq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the packed deque core: sizes, request/response structs,
// opcode, status and sequencer state enums. No dependencies.
package pdq_pkg;

  // Storage geometry
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned KEY_WIDTH = 16;
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  // Fixed field widths of the request and response
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned ITEM_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_HEAD   = 2'd0,
    OP_TAIL   = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DN_RD,
    S_DN_WR,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ITEM_W-1:0]   item_key;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

endpackage

// ===== sv/packed_deque_with_key_removal_core.sv =====
`timescale 1ns / 1ps
// Packed deque of nonzero keys with insert at head/tail and remove by key.
// Depends on pdq_pkg (sizes, request/response structs, enums).
//
// Usage:
//   Request channel (req_valid_i / req_stall_o / req_i) carries an opcode and
//   a key. Response channel (rsp_valid_o / rsp_stall_i / rsp_o) returns one
//   response per request: status, slot and the new occupancy.
//   Keys live in a single-port-read memory and are moved one entry at a time
//   by a small sequencer; one index counter and one key comparator do all
//   the work.
//   Steps per request before the response (n = occupancy before it):
//     full, zero key, unknown opcode, empty remove : none
//     insert at tail                               : key write
//     insert at head                               : n moves up, key write
//     remove, key at slot k (or miss, k = n-1)     : k+1 compares, then
//                                                    n-1-k moves down
//   Each compare or move waits on the registered memory read.
//   req_stall_o is high while a request is being worked on. A finished
//   response waits in the output register; the next request is accepted
//   meanwhile, and its response waits until the register drains.
//   Reset empties the list at once (occupancy zero); no clearing pass.
module packed_deque_with_key_removal_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  pdq_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output pdq_pkg::rsp_t rsp_o
);

  // Sequencer and datapath registers
  pdq_pkg::state_e                  state_q, state_d;
  logic [pdq_pkg::KEY_WIDTH-1:0]    key_q, key_d;
  logic [pdq_pkg::IDX_W-1:0]        idx_q, idx_d;
  logic [pdq_pkg::CNT_W-1:0]        at_q, at_d;
  logic [pdq_pkg::CNT_W-1:0]        count_q, count_d;
  pdq_pkg::status_e                 status_q, status_d;
  pdq_pkg::rsp_t                    rsp_q, rsp_d;
  logic                             rsp_valid_q, rsp_valid_d;

  // Key memory
  logic [pdq_pkg::KEY_WIDTH-1:0]    mem [pdq_pkg::DEPTH];
  logic [pdq_pkg::KEY_WIDTH-1:0]    rd_data_q;
  logic                             mem_we;
  logic [pdq_pkg::IDX_W-1:0]        mem_waddr;
  logic [pdq_pkg::KEY_WIDTH-1:0]    mem_wdata;
  logic [pdq_pkg::IDX_W-1:0]        mem_raddr;

  // Shared unit: index increment, count decrement and one key compare
  logic [pdq_pkg::CNT_W-1:0]        idx_inc;
  logic [pdq_pkg::CNT_W-1:0]        cnt_dec;
  logic                             key_hit;
  logic [pdq_pkg::KEY_WIDTH-1:0]    in_key;
  logic                             accept;
  logic                             is_full;
  logic                             rsp_free;

  assign idx_inc  = pdq_pkg::CNT_W'(idx_q) + pdq_pkg::CNT_W'(1);
  assign cnt_dec  = count_q - pdq_pkg::CNT_W'(1);
  assign key_hit  = (rd_data_q == key_q);
  assign in_key   = pdq_pkg::KEY_WIDTH'(req_i.item_key);
  assign accept   = req_valid_i && !req_stall_o;
  assign is_full  = (count_q == pdq_pkg::CNT_W'(pdq_pkg::DEPTH));
  assign rsp_free = !rsp_valid_q || !rsp_stall_i;

  assign req_stall_o = (state_q != pdq_pkg::S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdq_pkg::S_IDLE: begin
        if (accept) begin
          case (req_i.opcode)
            pdq_pkg::OP_HEAD: begin
              if (is_full || in_key == '0) begin
                state_d = pdq_pkg::S_RESP;
              end else if (count_q == '0) begin
                state_d = pdq_pkg::S_PUT;
              end else begin
                state_d = pdq_pkg::S_UP_RD;
              end
            end
            pdq_pkg::OP_TAIL: begin
              if (is_full || in_key == '0) begin
                state_d = pdq_pkg::S_RESP;
              end else begin
                state_d = pdq_pkg::S_PUT;
              end
            end
            pdq_pkg::OP_REMOVE: begin
              if (in_key == '0 || count_q == '0) begin
                state_d = pdq_pkg::S_RESP;
              end else begin
                state_d = pdq_pkg::S_SRCH_RD;
              end
            end
            default: state_d = pdq_pkg::S_RESP;
          endcase
        end
      end
      pdq_pkg::S_SRCH_RD: state_d = pdq_pkg::S_SRCH_CMP;
      pdq_pkg::S_SRCH_CMP: begin
        if (key_hit) begin
          state_d = (idx_inc < count_q) ? pdq_pkg::S_DN_RD : pdq_pkg::S_RESP;
        end else if (idx_inc == count_q) begin
          state_d = pdq_pkg::S_RESP;
        end else begin
          state_d = pdq_pkg::S_SRCH_RD;
        end
      end
      pdq_pkg::S_DN_RD: state_d = pdq_pkg::S_DN_WR;
      pdq_pkg::S_DN_WR: begin
        state_d = (idx_inc < cnt_dec) ? pdq_pkg::S_DN_RD : pdq_pkg::S_RESP;
      end
      pdq_pkg::S_UP_RD: state_d = pdq_pkg::S_UP_WR;
      pdq_pkg::S_UP_WR: begin
        state_d = (idx_q == pdq_pkg::IDX_W'(1)) ? pdq_pkg::S_PUT : pdq_pkg::S_UP_RD;
      end
      pdq_pkg::S_PUT: state_d = pdq_pkg::S_RESP;
      pdq_pkg::S_RESP: begin
        if (rsp_free) begin
          state_d = pdq_pkg::S_IDLE;
        end
      end
      default: state_d = pdq_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    key_d       = key_q;
    idx_d       = idx_q;
    at_d        = at_q;
    count_d     = count_q;
    status_d    = status_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = rd_data_q;
    mem_raddr   = idx_q;

    // drain the response register
    if (rsp_valid_q && !rsp_stall_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      pdq_pkg::S_IDLE: begin
        if (accept) begin
          key_d    = in_key;
          at_d     = '0;
          status_d = pdq_pkg::STAT_DONE;
          case (req_i.opcode)
            pdq_pkg::OP_HEAD: begin
              if (is_full) begin
                status_d = pdq_pkg::STAT_FULL;
              end
              idx_d = pdq_pkg::IDX_W'(count_q);
            end
            pdq_pkg::OP_TAIL: begin
              if (is_full) begin
                status_d = pdq_pkg::STAT_FULL;
              end else if (in_key != '0) begin
                at_d = count_q;
              end
              idx_d = pdq_pkg::IDX_W'(count_q);
            end
            pdq_pkg::OP_REMOVE: begin
              if (in_key == '0 || count_q == '0) begin
                status_d = pdq_pkg::STAT_MISSING;
              end
              idx_d = '0;
            end
            default: ;
          endcase
        end
      end
      // search: one entry read, then compared
      pdq_pkg::S_SRCH_RD: mem_raddr = idx_q;
      pdq_pkg::S_SRCH_CMP: begin
        if (key_hit) begin
          at_d = pdq_pkg::CNT_W'(idx_q);
          if (!(idx_inc < count_q)) begin
            count_d = cnt_dec;
          end
        end else if (idx_inc == count_q) begin
          status_d = pdq_pkg::STAT_MISSING;
        end else begin
          idx_d = pdq_pkg::IDX_W'(idx_inc);
        end
      end
      // close the gap: entry idx+1 moves down to idx
      pdq_pkg::S_DN_RD: mem_raddr = pdq_pkg::IDX_W'(idx_inc);
      pdq_pkg::S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        idx_d     = pdq_pkg::IDX_W'(idx_inc);
        if (!(idx_inc < cnt_dec)) begin
          count_d = cnt_dec;
        end
      end
      // open the head: entry idx-1 moves up to idx
      pdq_pkg::S_UP_RD: mem_raddr = idx_q - pdq_pkg::IDX_W'(1);
      pdq_pkg::S_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        idx_d     = idx_q - pdq_pkg::IDX_W'(1);
      end
      pdq_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = key_q;
        count_d   = count_q + pdq_pkg::CNT_W'(1);
      end
      pdq_pkg::S_RESP: begin
        if (rsp_free) begin
          rsp_valid_d     = 1'b1;
          rsp_d.status    = status_q;
          rsp_d.slot      = pdq_pkg::SLOT_W'(at_q);
          rsp_d.occupancy = pdq_pkg::OCC_W'(count_q);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdq_pkg::S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    idx_q    <= idx_d;
    at_q     <= at_d;
    status_q <= status_d;
    rsp_q    <= rsp_d;
  end

  // Key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

`ifndef ASSERT_OFF
  // occupancy never exceeds the list depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pdq_pkg::CNT_W'(pdq_pkg::DEPTH))
    else $error("occupancy above depth");

  // writes land inside the occupied region or one past it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> pdq_pkg::CNT_W'(mem_waddr) <= count_q)
    else $error("write beyond list tail");

  // a full response reports a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == pdq_pkg::STAT_FULL
      |-> rsp_o.occupancy == pdq_pkg::OCC_W'(pdq_pkg::DEPTH))
    else $error("full status with free slots");

  // occupancy changes only at the end of an insert or remove
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_d != count_q |-> state_q == pdq_pkg::S_PUT ||
      state_q == pdq_pkg::S_SRCH_CMP || state_q == pdq_pkg::S_DN_WR)
    else $error("occupancy changed outside update");
`endif

endmodule
